// ----- design/vrrb_pkg.sv -----
// shared types and constants of the variable-length record ring buffer
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package vrrb_pkg;

  localparam int PTR_W  = 11;
  localparam int ADDR_W = 10;
  localparam int BUF_BYTES = 1024;

  localparam logic [PTR_W-1:0] HDR_BYTES = 11'd8;
  localparam logic [PTR_W-1:0] MAX_TOTAL = 11'd72;
  localparam logic [PTR_W-1:0] USED_MIN  = 11'd9;
  localparam logic [PTR_W-1:0] USED_MAX  = 11'd1024;
  localparam logic [PTR_W-1:0] GUARD_MAX = 11'd1025;
  localparam logic [6:0]       MAX_REC   = 7'd64;

  localparam logic [2:0] OP_WRITE     = 3'd0;
  localparam logic [2:0] OP_OVERWRITE = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_PEEK      = 3'd3;
  localparam logic [2:0] OP_ALLOC     = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_TOO_BIG = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CONT, S_RES, S_RES2, S_HWR, S_FIN, S_HRD, S_DROP, S_LOC, S_ERR, S_STA, S_STE
  } state_t;

  typedef enum logic [1:0] {HR_DROP, HR_LOC, HR_LOC0} hret_t;

  typedef struct packed {
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic              hdr_clr;
    logic              hdr_cap;
    logic [2:0]        hdr_idx;
    logic              out_push;
    logic              out_use_ram;
    logic              out_last;
    logic [1:0]        out_status;
    logic [9:0]        out_offset;
    logic [6:0]        out_rlen;
  } cmd_t;

  typedef struct packed {
    logic [PTR_W-1:0] hdr_lo;
    logic             hdr_hi;
    logic             out_free;
  } dstat_t;

endpackage

`default_nettype wire

// ----- design/variable_length_record_ring_buffer.sv -----
// top level of the variable-length record ring buffer
// depends on vrrb_pkg, vrrb_ctrl, vrrb_datapath, vrrb_ram
//
//   channel   direction  handshake                     payload
//   s_*       in         s_tvalid / s_tready           s_tdata, s_tuser
//   m_*       out        m_tvalid / m_tready           m_tdata, m_tlast
//   apb       in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// a continuation write byte passes through S_CONT; a new record passes through S_RES, eight header
// byte writes in S_HWR through the single store port and S_FIN, with S_RES2 and a second header
// pass when the writer wraps past a skipped tail, plus a header read and S_DROP per dropped record
// read and peek: the header is fetched in S_HRD (fetched again when a skipped tail sends the reader
// back to offset 0), then each payload byte passes through S_STA and S_STE
// rst clears pointers and sets the buffer empty; the store itself is not cleared
// a stalled m_tready holds the sequencer at its next result; s_tready is high only when idle
`default_nettype none

module variable_length_record_ring_buffer
  import vrrb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // data_byte[7:0], length[14:8]
  input  wire logic [2:0]  s_tuser,   // operation[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,
  // m_tdata: out_byte[7:0], status[9:8], offset[19:10], record_length[26:20]
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cmd_t   cmd;
  dstat_t dstat;

  vrrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cmd      (cmd),
    .dstat    (dstat)
  );

  vrrb_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .dstat    (dstat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ----- design/vrrb_ram.sv -----
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module vrrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/vrrb_datapath.sv -----
// datapath: byte store, header assembly and result register
// depends on vrrb_pkg and vrrb_ram
`default_nettype none

module vrrb_datapath
  import vrrb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  cmd,
  output dstat_t     dstat,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  output logic [31:0] m_tdata,
  output logic       m_tlast
);

  logic [7:0]       rdata;
  logic [PTR_W-1:0] hdr_lo;
  logic             hdr_hi;
  logic             ovalid;
  logic [26:0]      opay;
  logic             olast;

  vrrb_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_store (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (cmd.mem_addr),
    .wdata (cmd.mem_wdata),
    .raddr (cmd.mem_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.hdr_clr) begin
      hdr_lo <= '0;
      hdr_hi <= 1'b0;
    end else if (cmd.hdr_cap) begin
      case (cmd.hdr_idx)
        3'd0: hdr_lo[7:0] <= rdata;
        3'd1: begin
          hdr_lo[10:8] <= rdata[2:0];
          hdr_hi       <= hdr_hi | (|rdata[7:3]);
        end
        default: hdr_hi <= hdr_hi | (|rdata);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.out_push) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      opay  <= {cmd.out_rlen, cmd.out_offset, cmd.out_status,
                cmd.out_use_ram ? rdata : 8'd0};
      olast <= cmd.out_last;
    end
  end

  assign dstat.hdr_lo   = hdr_lo;
  assign dstat.hdr_hi   = hdr_hi;
  assign dstat.out_free = !ovalid || m_tready;
  assign m_tvalid = ovalid;
  assign m_tdata  = {5'd0, opay};
  assign m_tlast  = olast;

endmodule

`default_nettype wire

// ----- design/vrrb_ctrl.sv -----
// controller: sequencer, ring pointers and the used_size register
// depends on vrrb_pkg
`default_nettype none

module vrrb_ctrl
  import vrrb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,
  input  wire logic [2:0]  s_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cmd_t             cmd,
  input  wire dstat_t      dstat
);

  state_t state, state_next;
  hret_t  hret, hret_next;
  logic [2:0]       op_q, op_q_next;
  logic [7:0]       d_q, d_q_next;
  logic [6:0]       len_q, len_q_next;
  logic [PTR_W-1:0] used, used_next;
  logic [PTR_W-1:0] wp, wp_next, rp, rp_next;
  logic             empty, empty_next;
  logic [6:0]       pending, pending_next;
  logic [ADDR_W-1:0] fill, fill_next;
  logic             disc, disc_next;
  logic [6:0]       cnt, cnt_next;
  logic [PTR_W-1:0] at, at_next;
  logic             hdr_zero, hdr_zero_next;
  logic             wrap_after, wrap_after_next;
  logic [PTR_W-1:0] saved, saved_next;
  logic             saved_flag, saved_flag_next;
  logic             ok, ok_next;
  logic [ADDR_W-1:0] pl, pl_next;
  logic [PTR_W-1:0] guard, guard_next;
  logic [6:0]       plen, plen_next;
  logic [1:0]       err_st, err_st_next;
  logic [6:0]       err_len, err_len_next;

  logic [PTR_W-1:0] total, room_end, gap, hdr_addr, rpn, wpn, stream_addr;
  logic             len_ok, t_zero, cfg_we;
  logic [PTR_W-1:0] cfg_v;
  logic [6:0]       pend_new;

  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] u);
    logic [PTR_W-1:0] r;
    r = p;
    if (p >= u || (u - p) <= HDR_BYTES) begin
      r = '0;
    end
    return r;
  endfunction

  assign total       = {4'd0, len_q} + HDR_BYTES;
  assign len_ok      = (len_q != 7'd0) && (len_q <= MAX_REC) && (total <= used);
  assign room_end    = used - wp;
  assign gap         = rp - wp;
  assign hdr_addr    = at + {4'd0, cnt};
  assign stream_addr = rp + HDR_BYTES + {4'd0, cnt};
  assign t_zero      = (dstat.hdr_lo == '0) && !dstat.hdr_hi;
  assign pend_new    = (len_q != 7'd0) ? len_q - 7'd1 : 7'd0;
  assign cfg_we      = psel && penable && pwrite && !paddr[2];
  assign cfg_v       = (pwdata[10:0] < USED_MIN) ? USED_MIN :
                       (pwdata[10:0] > USED_MAX) ? USED_MAX : pwdata[10:0];
  assign pready      = 1'b1;
  assign prdata      = {21'd0, used};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= USED_MAX;
      wp      <= '0;
      rp      <= '0;
      empty   <= 1'b1;
      pending <= '0;
      fill    <= '0;
      disc    <= 1'b0;
    end else begin
      state   <= state_next;
      used    <= used_next;
      wp      <= wp_next;
      rp      <= rp_next;
      empty   <= empty_next;
      pending <= pending_next;
      fill    <= fill_next;
      disc    <= disc_next;
    end
  end

  always_ff @(posedge clk) begin
    hret       <= hret_next;
    op_q       <= op_q_next;
    d_q        <= d_q_next;
    len_q      <= len_q_next;
    cnt        <= cnt_next;
    at         <= at_next;
    hdr_zero   <= hdr_zero_next;
    wrap_after <= wrap_after_next;
    saved      <= saved_next;
    saved_flag <= saved_flag_next;
    ok         <= ok_next;
    pl         <= pl_next;
    guard      <= guard_next;
    plen       <= plen_next;
    err_st     <= err_st_next;
    err_len    <= err_len_next;
  end

  always_comb begin
    state_next      = state;
    hret_next       = hret;
    op_q_next       = op_q;
    d_q_next        = d_q;
    len_q_next      = len_q;
    used_next       = used;
    wp_next         = wp;
    rp_next         = rp;
    empty_next      = empty;
    pending_next    = pending;
    fill_next       = fill;
    disc_next       = disc;
    cnt_next        = cnt;
    at_next         = at;
    hdr_zero_next   = hdr_zero;
    wrap_after_next = wrap_after;
    saved_next      = saved;
    saved_flag_next = saved_flag;
    ok_next         = ok;
    pl_next         = pl;
    guard_next      = guard;
    plen_next       = plen;
    err_st_next     = err_st;
    err_len_next    = err_len;
    rpn             = '0;
    wpn             = '0;
    s_tready        = 1'b0;
    cmd             = '0;

    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op_q_next  = s_tuser;
          d_q_next   = s_tdata[7:0];
          len_q_next = s_tdata[14:8];
          guard_next = '0;
          unique case (s_tuser) inside
            OP_WRITE, OP_OVERWRITE: begin
              state_next = (pending != 7'd0) ? S_CONT : S_RES;
            end
            OP_ALLOC: begin
              pending_next = '0;
              disc_next    = 1'b0;
              state_next   = S_RES;
            end
            OP_READ, OP_PEEK: begin
              pending_next = '0;
              disc_next    = 1'b0;
              if (empty) begin
                err_st_next  = ST_EMPTY;
                err_len_next = '0;
                state_next   = S_ERR;
              end else begin
                at_next    = rp;
                cnt_next   = '0;
                hret_next  = HR_LOC;
                state_next = S_HRD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_CONT: begin
        if (dstat.out_free) begin
          cmd.mem_we    = !disc;
          cmd.mem_addr  = fill;
          cmd.mem_wdata = d_q;
          if (!disc) begin
            fill_next = fill + 10'd1;
          end
          pending_next = pending - 7'd1;
          if (pending == 7'd1) begin
            disc_next = 1'b0;
          end
          cmd.out_push   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = disc ? ST_NO_ROOM : ST_OK;
          state_next     = S_IDLE;
        end
      end

      S_RES: begin
        saved_flag_next = 1'b0;
        cnt_next        = '0;
        if (!len_ok || (!empty && rp == wp)) begin
          ok_next    = 1'b0;
          state_next = S_FIN;
        end else if (empty || wp >= rp) begin
          if (room_end >= total) begin
            at_next         = wp;
            hdr_zero_next   = 1'b0;
            wrap_after_next = 1'b1;
            state_next      = S_HWR;
          end else if (room_end > HDR_BYTES) begin
            saved_next      = wp;
            saved_flag_next = 1'b1;
            at_next         = wp;
            hdr_zero_next   = 1'b1;
            state_next      = S_HWR;
          end else begin
            wp_next    = '0;
            state_next = S_RES2;
          end
        end else begin
          state_next = S_RES2;
        end
      end

      S_RES2: begin
        cnt_next = '0;
        if (empty || gap >= total) begin
          at_next         = wp;
          hdr_zero_next   = 1'b0;
          wrap_after_next = 1'b0;
          state_next      = S_HWR;
        end else begin
          if (saved_flag) begin
            wp_next = saved;
          end
          ok_next    = 1'b0;
          state_next = S_FIN;
        end
      end

      S_HWR: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_addr  = hdr_addr[ADDR_W-1:0];
        cmd.mem_wdata = (cnt == 7'd0 && !hdr_zero) ? total[7:0] : 8'd0;
        cnt_next      = cnt + 7'd1;
        if (cnt == 7'd7) begin
          if (hdr_zero) begin
            wp_next    = '0;
            state_next = S_RES2;
          end else begin
            if (empty) begin
              rp_next    = at;
              empty_next = 1'b0;
            end
            wpn = at + total;
            if (wrap_after) begin
              wpn = wrap_ptr(wpn, used);
            end
            wp_next    = wpn;
            pl_next    = at[ADDR_W-1:0] + 10'd8;
            ok_next    = 1'b1;
            state_next = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (op_q == OP_ALLOC) begin
          if (dstat.out_free) begin
            cmd.out_push   = 1'b1;
            cmd.out_last   = 1'b1;
            cmd.out_status = ok ? ST_OK : ST_NO_ROOM;
            cmd.out_offset = ok ? pl : 10'd0;
            state_next     = S_IDLE;
          end
        end else if (!ok && op_q == OP_OVERWRITE && len_ok && !empty &&
                     guard <= GUARD_MAX) begin
          guard_next = guard + 11'd1;
          at_next    = rp;
          cnt_next   = '0;
          hret_next  = HR_DROP;
          state_next = S_HRD;
        end else if (dstat.out_free) begin
          pending_next = pend_new;
          if (ok) begin
            cmd.mem_we    = 1'b1;
            cmd.mem_addr  = pl;
            cmd.mem_wdata = d_q;
            fill_next     = pl + 10'd1;
            disc_next     = 1'b0;
          end else begin
            disc_next = (pend_new != 7'd0);
          end
          cmd.out_push   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = ok ? ST_OK : ST_NO_ROOM;
          state_next     = S_IDLE;
        end
      end

      S_HRD: begin
        cmd.mem_addr = hdr_addr[ADDR_W-1:0];
        cmd.hdr_clr  = (cnt == 7'd0);
        cmd.hdr_cap  = (cnt != 7'd0);
        cmd.hdr_idx  = 3'(cnt - 7'd1);
        cnt_next     = cnt + 7'd1;
        if (cnt == 7'd8) begin
          state_next = (hret == HR_DROP) ? S_DROP : S_LOC;
        end
      end

      S_DROP: begin
        if (t_zero) begin
          rpn = '0;
          if (rp == '0) begin
            empty_next = 1'b1;
          end
        end else begin
          if (dstat.hdr_hi || dstat.hdr_lo >= used - rp) begin
            rpn = '0;
          end else begin
            rpn = rp + dstat.hdr_lo;
          end
          rpn = wrap_ptr(rpn, used);
        end
        if (rpn == wp) begin
          empty_next = 1'b1;
        end
        rp_next    = rpn;
        state_next = S_RES;
      end

      S_LOC: begin
        if (t_zero) begin
          if (hret == HR_LOC && rp != '0) begin
            rp_next    = '0;
            at_next    = '0;
            cnt_next   = '0;
            hret_next  = HR_LOC0;
            state_next = S_HRD;
          end else begin
            empty_next   = 1'b1;
            err_st_next  = ST_EMPTY;
            err_len_next = '0;
            state_next   = S_ERR;
          end
        end else if (dstat.hdr_hi || dstat.hdr_lo <= HDR_BYTES ||
                     dstat.hdr_lo > MAX_TOTAL) begin
          err_st_next  = ST_TOO_BIG;
          err_len_next = '0;
          state_next   = S_ERR;
        end else begin
          plen_next = 7'(dstat.hdr_lo - HDR_BYTES);
          if (7'(dstat.hdr_lo - HDR_BYTES) > len_q) begin
            err_st_next  = ST_TOO_BIG;
            err_len_next = 7'(dstat.hdr_lo - HDR_BYTES);
            state_next   = S_ERR;
          end else begin
            cnt_next   = '0;
            state_next = S_STA;
          end
        end
      end

      S_ERR: begin
        if (dstat.out_free) begin
          cmd.out_push   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = err_st;
          cmd.out_rlen   = err_len;
          state_next     = S_IDLE;
        end
      end

      S_STA: begin
        cmd.mem_addr = stream_addr[ADDR_W-1:0];
        state_next   = S_STE;
      end

      S_STE: begin
        cmd.mem_addr = stream_addr[ADDR_W-1:0];
        if (dstat.out_free) begin
          cmd.out_push    = 1'b1;
          cmd.out_use_ram = 1'b1;
          cmd.out_last    = ((cnt + 7'd1) == plen);
          cmd.out_status  = ST_OK;
          cmd.out_rlen    = plen;
          cnt_next        = cnt + 7'd1;
          if ((cnt + 7'd1) == plen) begin
            if (op_q == OP_READ) begin
              rpn     = wrap_ptr(rp + HDR_BYTES + {4'd0, plen}, used);
              rp_next = rpn;
              if (rpn == wp) begin
                empty_next = 1'b1;
              end
            end
            state_next = S_IDLE;
          end else begin
            state_next = S_STA;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (cfg_we) begin
      used_next    = cfg_v;
      wp_next      = '0;
      rp_next      = '0;
      empty_next   = 1'b1;
      pending_next = '0;
      fill_next    = '0;
      disc_next    = 1'b0;
    end
  end

endmodule

`default_nettype wire
